/* rtl/ihs_pkg.sv */
// package for the integer hash set: sizes, commands, payload and control structs
// no dependencies
package ihs_pkg;

  localparam int unsigned MaxBuckets     = 16;
  localparam int unsigned SlotsPerBucket = 4;
  localparam int unsigned TotalSlots     = MaxBuckets * SlotsPerBucket;
  localparam int unsigned SlotIdxW       = $clog2(TotalSlots);
  localparam int unsigned SlotSelW       = (SlotsPerBucket > 1) ? $clog2(SlotsPerBucket) : 1;
  localparam int unsigned BucketW        = (MaxBuckets > 1) ? $clog2(MaxBuckets) : 1;
  localparam int unsigned CountW         = 7;
  localparam int unsigned ModW           = 5;
  localparam int unsigned ModBitsW       = $clog2(32 + 1);

  localparam logic [1:0] CmdAdd      = 2'd0;
  localparam logic [1:0] CmdContains = 2'd1;
  localparam logic [1:0] CmdRemove   = 2'd2;
  localparam logic [1:0] CmdClear    = 2'd3;

  localparam logic [1:0] RegBucketCount = 2'd0;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic              success;
    logic              bucket_full;
    logic [CountW-1:0] element_count;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture item, start modulo
    logic mod_step;   // one restoring step
    logic scan_rd;    // issue slot read
    logic scan_chk;   // check returned slot, advance
    logic commit;     // apply add or remove, build result
    logic clr_all;    // drop all valid bits, zero the count
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mod_done;
    logic scan_last;
    logic is_clear;
  } dp_sts_t;

endpackage

/* rtl/integer_hash_set_unit.sv */
// top level of the integer hash set: apb register, controller and datapath
// depends on ihs_pkg, ihs_ctrl, ihs_dp
//
//   beat       valid          stall          payload
//   input      in_valid_i     in_stall_o     in_item_i  (cmd, value)
//   output     out_valid_o    out_stall_i    out_item_o (success, bucket_full, element_count)
//   config     apb psel/penable/pwrite, paddr[2:2] register bucket_count
//
// add, contains and remove take the beat in idle, run 32 steps of the bit-serial
// modulo and see it done, then read and check each of four slots, then commit
// clear skips the modulo and the scan; valid bits reset at once, no clearing pass
// the next item enters as soon as the last result leaves its register
module integer_hash_set_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ihs_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ihs_pkg::out_item_t  out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:2]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import ihs_pkg::*;

  logic [ModW-1:0] bucket_count_q;
  dp_cmd_t         cmd;
  dp_sts_t         sts;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {{(32 - ModW){1'b0}}, bucket_count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= ModW'(16);
    end else if (psel && penable && pwrite && paddr == RegBucketCount[0]) begin
      bucket_count_q <= pwdata[ModW-1:0];
    end
  end

  ihs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ihs_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_item_i     (in_item_i),
    .bucket_count_i(bucket_count_q),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_item_o    (out_item_o)
  );

  // register writes only while no item is in flight
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite |-> !out_valid_o && !in_stall_o)
    else $error("config write while busy");

endmodule

/* rtl/ihs_ram.sv */
// generic simple dual port ram (one write port, one read port) with registered read
// no dependencies
module ihs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/ihs_ctrl.sv */
// controller for the integer hash set: sequences modulo, bucket scan and commit
// depends on ihs_pkg
module ihs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  ihs_pkg::dp_sts_t  sts_i,
  output ihs_pkg::dp_cmd_t  cmd_o
);
  import ihs_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMod  = 3'd1;
  localparam logic [2:0] StRd   = 3'd2;
  localparam logic [2:0] StChk  = 3'd3;
  localparam logic [2:0] StCmt  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;
  logic       accept;

  // a new item enters only in idle and not while the previous result is held by a stall
  assign in_stall_o  = (state_q != StIdle) || (ovalid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q && out_stall_i;
    cmd_o    = '0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = StMod;
        end
      end
      StMod: begin
        if (sts_i.is_clear) begin
          cmd_o.clr_all = 1'b1;
          state_d       = StCmt;
        end else if (sts_i.mod_done) begin
          state_d = StRd;
        end else begin
          cmd_o.mod_step = 1'b1;
        end
      end
      StRd: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = StChk;
      end
      StChk: begin
        cmd_o.scan_chk = 1'b1;
        state_d        = sts_i.scan_last ? StCmt : StRd;
      end
      StCmt: begin
        if (!(ovalid_q && out_stall_i)) begin
          cmd_o.commit = 1'b1;
          ovalid_d     = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == StIdle)
    else $error("load outside idle");

endmodule

/* rtl/ihs_dp.sv */
// datapath for the integer hash set: restoring modulo, slot ram, valid bits, count
// depends on ihs_pkg and ihs_ram
module ihs_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ihs_pkg::in_item_t  in_item_i,
  input  logic [4:0]         bucket_count_i,
  input  ihs_pkg::dp_cmd_t   cmd_i,
  output ihs_pkg::dp_sts_t   sts_o,
  output ihs_pkg::out_item_t out_item_o
);
  import ihs_pkg::*;

  logic [1:0]          op_q;
  logic [31:0]         val_q;
  logic [31:0]         quo_q;     // magnitude shifted out msb first
  logic [ModW-1:0]     rem_q;
  logic [ModW-1:0]     div_q;
  logic [ModBitsW-1:0] bits_q;
  logic [SlotSelW:0]   sel_q;
  logic                hit_q, free_q;
  logic [SlotIdxW-1:0] hit_idx_q, free_idx_q;
  logic [TotalSlots-1:0] valid_q;
  logic [CountW-1:0]   cnt_q;
  out_item_t           res_q;
  logic [31:0]         rdata;
  logic [ModW:0]       trial;
  logic [SlotIdxW-1:0] slot_idx, rd_idx_q;
  logic                wr_en;
  logic [31:0]         mag;
  logic [ModW-1:0]     div_sat;

  assign mag     = in_item_i.value[31] ? (~in_item_i.value + 32'd1) : in_item_i.value;
  assign div_sat = (bucket_count_i == '0) ? ModW'(1) :
                   (bucket_count_i > ModW'(MaxBuckets)) ? ModW'(MaxBuckets) : bucket_count_i;
  assign trial   = {rem_q, quo_q[31]} - {1'b0, div_q};

  assign slot_idx = SlotIdxW'(rem_q) * SlotIdxW'(SlotsPerBucket)
                  + SlotIdxW'(sel_q[SlotSelW-1:0]);

  assign wr_en = cmd_i.commit && (op_q == CmdAdd) && !hit_q && free_q;

  ihs_ram #(.Width(32), .Depth(TotalSlots)) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(free_idx_q),
    .wdata_i(val_q),
    .raddr_i(slot_idx),
    .rdata_o(rdata)
  );

  assign sts_o.mod_done  = (bits_q == '0);
  assign sts_o.scan_last = (sel_q == (SlotSelW + 1)'(SlotsPerBucket - 1));
  assign sts_o.is_clear  = (op_q == CmdClear);
  assign out_item_o      = res_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= in_item_i.cmd;
      val_q     <= in_item_i.value;
      quo_q     <= mag;
      rem_q     <= '0;
      div_q     <= div_sat;
      bits_q    <= ModBitsW'(32);
      sel_q     <= '0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      hit_idx_q <= '0;
      free_idx_q <= '0;
    end
    if (cmd_i.mod_step) begin
      // restoring step, remainder stays below the divisor
      if (!trial[ModW]) rem_q <= trial[ModW-1:0];
      else              rem_q <= {rem_q[ModW-2:0], quo_q[31]};
      quo_q  <= {quo_q[30:0], 1'b0};
      bits_q <= bits_q - ModBitsW'(1);
    end
    if (cmd_i.scan_rd) begin
      rd_idx_q <= slot_idx;
    end
    if (cmd_i.scan_chk) begin
      if (valid_q[rd_idx_q]) begin
        if (!hit_q && rdata == val_q) begin
          hit_q     <= 1'b1;
          hit_idx_q <= rd_idx_q;
        end
      end else if (!free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= rd_idx_q;
      end
      sel_q <= sel_q + (SlotSelW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      cnt_q   <= '0;
      res_q   <= '0;
    end else begin
      if (cmd_i.clr_all) begin
        valid_q <= '0;
        cnt_q   <= '0;
      end
      if (cmd_i.commit) begin
        res_q.success       <= 1'b0;
        res_q.bucket_full   <= 1'b0;
        res_q.element_count <= cnt_q;
        case (op_q)
          CmdAdd: begin
            if (!hit_q) begin
              if (free_q) begin
                valid_q[free_idx_q] <= 1'b1;
                cnt_q               <= cnt_q + CountW'(1);
                res_q.element_count <= cnt_q + CountW'(1);
                res_q.success       <= 1'b1;
              end else begin
                res_q.bucket_full <= 1'b1;
              end
            end
          end
          CmdContains: res_q.success <= hit_q;
          CmdRemove: begin
            if (hit_q) begin
              valid_q[hit_idx_q]  <= 1'b0;
              cnt_q               <= cnt_q - CountW'(1);
              res_q.element_count <= cnt_q - CountW'(1);
              res_q.success       <= 1'b1;
            end
          end
          CmdClear: res_q.success <= 1'b1;
          default: res_q.success <= 1'b0;
        endcase
      end
    end
  end

  a_rem_small: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_rd |-> rem_q < div_q)
    else $error("remainder not reduced");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountW'(TotalSlots))
    else $error("element count overflow");
  a_cnt_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == CountW'($countones(valid_q)))
    else $error("count differs from valid bits");

endmodule

/* test/tb_top.sv */
// testbench for integer_hash_set_unit: directed table then random commands,
// checked beat by beat against an in-bench model of the hash set; needs ihs_pkg
module tb_top;
  import ihs_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:2] paddr = 1'b0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  integer_hash_set_unit DUT (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // set model
  logic [31:0] set_vals [TotalSlots];
  logic set_used [TotalSlots];
  int unsigned set_count;
  int unsigned n_buckets;
  out_item_t pending_results[$];
  int fails = 0;
  int send_gap = 0, recv_gap = 0;
  int hold_cycles = 0;

  function automatic out_item_t model_apply(in_item_t it);
    out_item_t r;
    logic [31:0] mag;
    int unsigned md, base, hit, free_slot;
    r = '0;
    if (it.cmd == CmdClear) begin
      for (int i = 0; i < TotalSlots; i++) set_used[i] = 1'b0;
      set_count = 0;
      r.success = 1'b1;
    end else begin
      md = (n_buckets == 0) ? 1 : (n_buckets > MaxBuckets ? MaxBuckets : n_buckets);
      mag = it.value[31] ? (~it.value + 32'd1) : it.value;
      base = (mag % md) * SlotsPerBucket;
      hit = TotalSlots;
      free_slot = TotalSlots;
      for (int s = 0; s < SlotsPerBucket; s++) begin
        if (set_used[base+s]) begin
          if (hit == TotalSlots && set_vals[base+s] == it.value) hit = base + s;
        end else if (free_slot == TotalSlots) begin
          free_slot = base + s;
        end
      end
      case (it.cmd)
        CmdAdd: begin
          if (hit == TotalSlots) begin
            if (free_slot == TotalSlots) begin
              r.bucket_full = 1'b1;
            end else begin
              set_vals[free_slot] = it.value;
              set_used[free_slot] = 1'b1;
              set_count++;
              r.success = 1'b1;
            end
          end
        end
        CmdContains: r.success = (hit != TotalSlots);
        default: begin
          if (hit != TotalSlots) begin
            set_used[hit] = 1'b0;
            if (set_count > 0) set_count--;
            r.success = 1'b1;
          end
        end
      endcase
    end
    r.element_count = set_count[CountW-1:0];
    return r;
  endfunction

  task automatic write_buckets(int unsigned v);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= RegBucketCount[0]; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    n_buckets = v & 32'h1f;
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  // send one beat; check against a typed value when given
  task automatic send_beat(in_item_t it, bit typed, out_item_t want);
    out_item_t r;
    while (send_gap > 0 && $urandom_range(99) < send_gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    r = model_apply(it);
    if (typed && r != want) begin
      $error("table row disagrees with model: %h vs %h", want, r);
      fails++;
    end
    pending_results.push_back(r);
    in_item_i <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // receiver: stall driver and result checker
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %h", out_item_o);
        fails++;
      end else begin
        e = pending_results.pop_front();
        if (out_item_o.success !== e.success) begin
          $error("success: expected %0d actual %0d", e.success, out_item_o.success);
          fails++;
        end
        if (out_item_o.bucket_full !== e.bucket_full) begin
          $error("bucket_full: expected %0d actual %0d", e.bucket_full,
                 out_item_o.bucket_full);
          fails++;
        end
        if (out_item_o.element_count !== e.element_count) begin
          $error("element_count: expected %0d actual %0d", e.element_count,
                 out_item_o.element_count);
          fails++;
        end
      end
    end
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= (recv_gap > 0) && ($urandom_range(99) < recv_gap);
    end
  end

  typedef struct {
    logic [1:0] cmd;
    logic [31:0] value;
    bit typed;
    logic ok, full;
    int cnt;
  } table_row_t;

  // values 0, 16, 32 and 32'h80000000 share bucket 0 at 16 buckets; 64 is the fifth
  table_row_t dir_rows[] = '{
    '{CmdContains, 32'd0, 1, 0, 0, 0},
    '{CmdRemove, 32'd5, 1, 0, 0, 0},
    '{CmdAdd, 32'd0, 1, 1, 0, 1},
    '{CmdAdd, 32'd0, 1, 0, 0, 1},
    '{CmdAdd, 32'd16, 1, 1, 0, 2},
    '{CmdAdd, 32'd32, 1, 1, 0, 3},
    '{CmdAdd, 32'h80000000, 1, 1, 0, 4},
    '{CmdAdd, 32'd64, 1, 0, 1, 4},
    '{CmdContains, 32'h80000000, 1, 1, 0, 4},
    '{CmdAdd, 32'h7fffffff, 1, 1, 0, 5},
    '{CmdAdd, 32'hffffffff, 1, 1, 0, 6},
    '{CmdAdd, 32'hffffffff, 1, 0, 0, 6},
    '{CmdContains, 32'h7fffffff, 1, 1, 0, 6},
    '{CmdRemove, 32'd16, 1, 1, 0, 5},
    '{CmdAdd, 32'd64, 1, 1, 0, 6},
    '{CmdContains, 32'hfffffff1, 0, 0, 0, 0},
    '{CmdRemove, 32'h80000000, 1, 1, 0, 5},
    '{CmdClear, 32'hdeadbeef, 1, 1, 0, 0},
    '{CmdContains, 32'd0, 1, 0, 0, 0}
  };

  function automatic in_item_t rand_item(int unsigned mode);
    in_item_t it;
    int unsigned p;
    p = $urandom_range(999);
    it.cmd = (p < 450) ? CmdAdd : (p < 700) ? CmdContains : (p < 990) ? CmdRemove : CmdClear;
    case (mode)
      0: it.value = $signed($urandom_range(40)) - 20;
      1: it.value = $urandom();
      default: it.value = {$urandom_range(1) ? 28'hfffffff : 28'h0, 4'($urandom())};
    endcase
    return it;
  endfunction

  initial begin
    in_item_t it;
    out_item_t w;
    int unsigned cfg_list[] = '{16, 1, 0, 7, 31, 3, 16};
    for (int i = 0; i < TotalSlots; i++) set_used[i] = 1'b0;
    set_count = 0;
    n_buckets = 16;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      it.cmd = dir_rows[i].cmd;
      it.value = dir_rows[i].value;
      w.success = dir_rows[i].ok;
      w.bucket_full = dir_rows[i].full;
      w.element_count = CountW'(dir_rows[i].cnt);
      send_beat(it, dir_rows[i].typed, w);
    end
    for (int ph = 0; ph < 3; ph++) begin
      send_gap = (ph == 0) ? 11 : (ph == 1) ? 70 : 0;
      recv_gap = (ph == 0) ? 70 : (ph == 1) ? 11 : 0;
      foreach (cfg_list[c]) begin
        drain();
        write_buckets(cfg_list[c]);
        if (ph == 2 && c == 1) hold_cycles <= 400;
        for (int k = 0; k < 63; k++) send_beat(rand_item($urandom_range(2)), 0, '0);
        if (c == 3) drain();
      end
    end
    drain();
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
